>>> design/bdvs_pkg.sv
// Package for the bounded deque with value search.
// Holds opcode and status codes and the fixed stream field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdvs_pkg;

    // Fixed field widths of the stream channels
    localparam int OPCODE_W    = 3;
    localparam int OPERAND_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int OUT_DATA_W  = 8;

    // Operation carried in the input tuser
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_FIND       = 3'd4,
        OP_DELETE     = 3'd5
    } t_opcode;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

`default_nettype wire

>>> design/bdvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/bdvs_unit.sv
// Shared address and compare unit: maps a logical position to a physical
// slot of the circular store and compares a read entry with the search key.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdvs_unit #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic [$clog2(DEPTH)-1:0] i_head,
    input  wire logic [$clog2(DEPTH)-1:0] i_logical,
    input  wire logic [VALUE_WIDTH-1:0]   i_rdata,
    input  wire logic [VALUE_WIDTH-1:0]   i_key,
    output logic      [$clog2(DEPTH)-1:0] o_addr,
    output logic                          o_match
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

    logic [AW:0] sum;
    logic [AW:0] wrapped;

    // Add with one conditional subtract: the sum stays below twice the depth
    assign sum     = {1'b0, i_head} + {1'b0, i_logical};
    assign wrapped = sum - DEPTH_W;
    assign o_addr  = (sum >= DEPTH_W) ? wrapped[AW-1:0] : sum[AW-1:0];

    // Key compare
    assign o_match = (i_rdata == i_key);

endmodule

`default_nettype wire

>>> design/bounded_deque_with_value_search.sv
// Top level of the bounded deque with value search: handshake, sequencer,
// output register. Depends on bdvs_pkg, bdvs_ram and bdvs_unit.
//
// Usage:
//   Input channel (s_axis): tuser carries the opcode (push back, push front,
//   pop back, pop front, find, delete value), tdata the operand value.
//   Output channel (m_axis): one result item per input item with status,
//   found flag and the entry count after the operation.
//   One item is worked on at a time; o_s_axis_tready is high while the
//   sequencer is idle, also while a previous result still waits in the
//   output register. The next item can be taken in the same cycle as the
//   result goes valid.
//   Find stops at the first match. Delete scans all live entries, then drops
//   a matching front entry, else a matching back entry, else closes up the
//   later entries over the first match.
//   The entry RAM has a single read port and there is one shared
//   address/compare unit; scans and close-ups handle one entry per cycle.
//   Reset clears the head and the count; the entry RAM is not cleared and
//   needs no clearing pass, since only live entries are read.
//   A stalled receiver holds the result in the output register; a finished
//   item waits in its last state until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_value_search #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input item
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: [31:0] operand_value
    input  wire logic [31:0] i_s_axis_tdata,
    // tuser: [2:0] opcode
    input  wire logic [2:0]  i_s_axis_tuser,
    // Result item
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: [1:0] status, [2] found, [7:3] entry_count
    output logic [7:0]       o_m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_SCAN    = 6'b000100,
        S_RESOLVE = 6'b001000,
        S_SHIFT   = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    // Control registers
    t_state                              r_state, n_state;
    logic [AW-1:0]                       r_head, n_head;
    logic [CW-1:0]                       r_count, n_count;
    logic                                r_pend, n_pend;
    logic                                r_out_valid, n_out_valid;

    // Payload registers
    bdvs_pkg::t_opcode                   r_op, n_op;
    logic [VALUE_WIDTH-1:0]              r_key, n_key;
    logic [CW-1:0]                       r_idx, n_idx;
    logic [CW-1:0]                       r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]                       r_cmp_addr, n_cmp_addr;
    logic [CW-1:0]                       r_first, n_first;
    logic [AW-1:0]                       r_first_addr, n_first_addr;
    logic                                r_have_first, n_have_first;
    logic                                r_back_match, n_back_match;
    logic [AW-1:0]                       r_waddr, n_waddr;
    bdvs_pkg::t_status                   r_status, n_status;
    logic                                r_found, n_found;
    logic [bdvs_pkg::OUT_DATA_W-1:0]     r_out_data, n_out_data;

    // Datapath wires
    logic [AW-1:0]                       unit_logical;
    logic [AW-1:0]                       unit_addr;
    logic                                unit_match;
    logic [VALUE_WIDTH-1:0]              ram_rdata;
    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    logic [VALUE_WIDTH-1:0]              ram_wdata;

    logic                                in_accept;
    logic                                is_full;
    logic                                is_empty;
    logic                                issue;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign issue     = (r_idx < r_count);

    // Entry store
    bdvs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (unit_addr),
        .o_rdata (ram_rdata)
    );

    // Shared address and compare unit
    bdvs_unit #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_unit (
        .i_head    (r_head),
        .i_logical (unit_logical),
        .i_rdata   (ram_rdata),
        .i_key     (r_key),
        .o_addr    (unit_addr),
        .o_match   (unit_match)
    );

    // Select the logical position fed to the shared unit
    always_comb begin
        unit_logical = '0;
        case (r_state)
            S_EXEC: begin
                case (r_op)
                    bdvs_pkg::OP_PUSH_BACK:  unit_logical = r_count[AW-1:0];
                    bdvs_pkg::OP_PUSH_FRONT: unit_logical = AW'(DEPTH - 1);
                    bdvs_pkg::OP_POP_FRONT:  unit_logical = AW'(1);
                    default:                 unit_logical = '0;
                endcase
            end
            S_SCAN:    unit_logical = r_idx[AW-1:0];
            S_SHIFT:   unit_logical = r_idx[AW-1:0];
            S_RESOLVE: unit_logical = AW'(1);
            default:   unit_logical = '0;
        endcase
    end

    // Drive the RAM write port: pushes in EXEC, close-up moves in SHIFT
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = unit_addr;
        ram_wdata = r_key;
        if (r_state == S_EXEC && !is_full &&
            (r_op == bdvs_pkg::OP_PUSH_BACK || r_op == bdvs_pkg::OP_PUSH_FRONT)) begin
            ram_we = 1'b1;
        end else if (r_state == S_SHIFT && r_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_waddr;
            ram_wdata = ram_rdata;
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_addr   = r_cmp_addr;
        n_first      = r_first;
        n_first_addr = r_first_addr;
        n_have_first = r_have_first;
        n_back_match = r_back_match;
        n_waddr      = r_waddr;
        n_status     = r_status;
        n_found      = r_found;
        n_out_data   = r_out_data;

        // Drop the result once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op     = bdvs_pkg::t_opcode'(i_s_axis_tuser);
                    n_key    = VALUE_WIDTH'(i_s_axis_tdata);
                    n_status = bdvs_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                n_idx        = '0;
                n_pend       = 1'b0;
                n_have_first = 1'b0;
                n_back_match = 1'b0;
                n_state      = S_DONE;
                case (r_op)
                    bdvs_pkg::OP_PUSH_BACK: begin
                        if (is_full) n_status = bdvs_pkg::ST_FULL;
                        else         n_count  = r_count + CW'(1);
                    end
                    bdvs_pkg::OP_PUSH_FRONT: begin
                        if (is_full) begin
                            n_status = bdvs_pkg::ST_FULL;
                        end else begin
                            n_head  = unit_addr;
                            n_count = r_count + CW'(1);
                        end
                    end
                    bdvs_pkg::OP_POP_BACK: begin
                        if (is_empty) n_status = bdvs_pkg::ST_EMPTY;
                        else          n_count  = r_count - CW'(1);
                    end
                    bdvs_pkg::OP_POP_FRONT: begin
                        if (is_empty) begin
                            n_status = bdvs_pkg::ST_EMPTY;
                        end else begin
                            n_head  = unit_addr;
                            n_count = r_count - CW'(1);
                        end
                    end
                    bdvs_pkg::OP_FIND: begin
                        if (!is_empty) n_state = S_SCAN;
                    end
                    bdvs_pkg::OP_DELETE: begin
                        if (is_empty) n_status = bdvs_pkg::ST_EMPTY;
                        else          n_state  = S_SCAN;
                    end
                    default: n_state = S_DONE;
                endcase
            end

            S_SCAN: begin
                // Issue the next read
                if (issue) begin
                    n_idx      = r_idx + CW'(1);
                    n_pend     = 1'b1;
                    n_cmp_idx  = r_idx;
                    n_cmp_addr = unit_addr;
                end else begin
                    n_pend = 1'b0;
                end
                // Scan finished with no early exit
                if (!issue && !r_pend) begin
                    n_state = (r_op == bdvs_pkg::OP_FIND) ? S_DONE : S_RESOLVE;
                end
                // Evaluate the entry read last cycle
                if (r_pend && unit_match) begin
                    if (r_op == bdvs_pkg::OP_FIND) begin
                        n_found = 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        if (!r_have_first) begin
                            n_have_first = 1'b1;
                            n_first      = r_cmp_idx;
                            n_first_addr = r_cmp_addr;
                        end
                        if (r_cmp_idx == r_count - CW'(1)) begin
                            n_back_match = 1'b1;
                        end
                    end
                end
            end

            S_RESOLVE: begin
                n_state = S_DONE;
                if (r_have_first && r_first == '0) begin
                    // Front entry matches: drop it
                    n_head  = unit_addr;
                    n_count = r_count - CW'(1);
                end else if (r_back_match) begin
                    // Back entry matches: drop it
                    n_count = r_count - CW'(1);
                end else if (r_have_first) begin
                    // Middle entry: close up the later entries
                    n_idx   = r_first + CW'(1);
                    n_waddr = r_first_addr;
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    n_status = bdvs_pkg::ST_NOT_FOUND;
                end
            end

            S_SHIFT: begin
                // Read entry j+1, write it one slot toward the front
                if (issue) begin
                    n_idx      = r_idx + CW'(1);
                    n_pend     = 1'b1;
                    n_cmp_addr = unit_addr;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_waddr = r_cmp_addr;
                end
                if (!issue && !r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {bdvs_pkg::COUNT_OUT_W'(r_count), r_found, r_status};
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_cmp_addr   <= n_cmp_addr;
        r_first      <= n_first;
        r_first_addr <= n_first_addr;
        r_have_first <= n_have_first;
        r_back_match <= n_back_match;
        r_waddr      <= n_waddr;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_data   <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_EXEC || r_state == S_SHIFT))
        else $error("entry store written outside push or close-up");

    a_head_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC && r_state != S_RESOLVE) |=> $stable(r_head))
        else $error("head moved outside exec or resolve");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN || r_state == S_SHIFT))
        else $error("read pending outside scan or shift");

endmodule

`default_nettype wire
